// ----- hdl/cpsat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsat_pkg
// shared types and constants of the polygon separating-axis collision core
// ----------------------------------------------------------------------------
package cpsat_pkg;

    // one vertex word as it travels from the front end to the test engine
    typedef struct packed {
        logic               last;
        logic               sel;
        logic        [11:0] angle;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_x;
        logic signed [15:0] vtx_y;
        logic signed [15:0] vtx_x;
    } t_vtx;

    localparam int VTX_W = $bits(t_vtx);

    // quarter-wave sine polynomial coefficients in Q14, and quarter-turn angle constants
    localparam logic [14:0] SIN_K0 = 15'd10512;
    localparam logic [14:0] SIN_K1 = 15'd1160;
    localparam logic [15:0] SIN_K2 = 16'd25736;
    localparam logic [11:0] ANG_QTR = 12'd1024;
    localparam logic [10:0] QTR_Q = 11'd1024;

    // rounding offset before the Q22 to Q8 shift
    localparam logic signed [33:0] ROT_RND = 34'sd8192;

    // rotated local coordinate, normal and projection widths
    localparam int LOC_W = 20;
    localparam int NRM_W = LOC_W + 1;
    localparam int GLB_W = 25;
    localparam int PRD_W = GLB_W + NRM_W;
    localparam int DOT_W = PRD_W + 1;

endpackage

// ----- hdl/cpsat_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsat_front
// takes vertex words, assigns store slots, tracks counts and drops overflow
// ----------------------------------------------------------------------------
module cpsat_front #(
    parameter  int MAX_VERTICES = 16,
    localparam int CW = $clog2(MAX_VERTICES + 1),
    localparam int IW = $clog2(MAX_VERTICES),
    localparam int AW = IW + 1,
    localparam int QW = cpsat_pkg::VTX_W + 1 + AW + 2 * CW + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  cpsat_pkg::t_vtx        i_vtx,
    output logic                   o_push,
    input  logic                   i_full,
    output logic [QW-1:0]          o_entry
);
    logic [CW-1:0] r_cnt [2];
    logic          r_ovf;

    logic          w_acc;
    logic          w_drop;
    logic [CW-1:0] n_cnt_a;
    logic [CW-1:0] n_cnt_b;
    logic          n_ovf;
    logic [AW-1:0] w_addr;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;
    assign o_push  = w_acc;

    always_comb begin
        w_drop  = (r_cnt[i_vtx.sel] == CW'(MAX_VERTICES));
        w_addr  = {i_vtx.sel, r_cnt[i_vtx.sel][IW-1:0]};
        n_cnt_a = r_cnt[0];
        n_cnt_b = r_cnt[1];
        if (!w_drop) begin
            if (i_vtx.sel) n_cnt_b = r_cnt[1] + CW'(1);
            else           n_cnt_a = r_cnt[0] + CW'(1);
        end
        n_ovf = r_ovf | w_drop;
    end

    // fields from the lowest bit: vertex, store enable, slot, count a, count b, overflow
    assign o_entry = {n_ovf, n_cnt_b, n_cnt_a, w_addr, !w_drop, i_vtx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_ovf    <= 1'b0;
        end else if (w_acc) begin
            if (i_vtx.last && i_vtx.sel) begin
                r_cnt[0] <= '0;
                r_cnt[1] <= '0;
                r_ovf    <= 1'b0;
            end else begin
                r_cnt[0] <= n_cnt_a;
                r_cnt[1] <= n_cnt_b;
                r_ovf    <= n_ovf;
            end
        end
    end

endmodule

// ----- hdl/cpsat_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsat_queue
// two-entry queue between the front end and the test engine
// ----------------------------------------------------------------------------
module cpsat_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop && o_valid) r_rp <= !r_rp;
            case ({i_push, i_pop && o_valid})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hdl/cpsat_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsat_back
// vertex store, sine unit, rotation and separating-axis projection engine
// ----------------------------------------------------------------------------
module cpsat_back #(
    parameter  int MAX_VERTICES = 16,
    localparam int CW = $clog2(MAX_VERTICES + 1),
    localparam int IW = $clog2(MAX_VERTICES),
    localparam int AW = IW + 1,
    localparam int VW = cpsat_pkg::VTX_W,
    localparam int QW = VW + 1 + AW + 2 * CW + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_pop,
    input  logic [QW-1:0] i_entry,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_collides,
    output logic          o_overflow
);
    localparam int LW = cpsat_pkg::LOC_W;
    localparam int NW = cpsat_pkg::NRM_W;
    localparam int GW = cpsat_pkg::GLB_W;
    localparam int PW = cpsat_pkg::PRD_W;
    localparam int DW = cpsat_pkg::DOT_W;
    localparam int DEPTH = 2 << IW;

    typedef enum logic [3:0] {
        S_IDLE, S_TRIG, S_ROT, S_EDGE0, S_EDGE1, S_EDGE2, S_PROJ, S_CMP, S_DONE
    } t_state;

    // queue word split
    cpsat_pkg::t_vtx w_vtx;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [CW-1:0]   w_cnt_a;
    logic [CW-1:0]   w_cnt_b;
    logic            w_ovf;

    assign {w_ovf, w_cnt_b, w_cnt_a, w_waddr, w_we, w_vtx} = i_entry;

    t_state r_state;

    logic signed [15:0] r_st_x [DEPTH];
    logic signed [15:0] r_st_y [DEPTH];
    logic signed [LW-1:0] r_loc_x [DEPTH];
    logic signed [LW-1:0] r_loc_y [DEPTH];

    logic signed [23:0] r_pose_x [2];
    logic signed [23:0] r_pose_y [2];
    logic        [11:0] r_ang [2];
    logic [CW-1:0]      r_cnt_a;
    logic [CW-1:0]      r_cnt_b;
    logic               r_tst_ovf;
    logic               r_tst_col;
    logic               r_res_ovf;
    logic               r_res_col;

    // sine unit
    logic signed [15:0] r_sin [2];
    logic signed [15:0] r_cos [2];
    logic [1:0]         r_tk;
    logic [2:0]         r_ts;
    logic [14:0]        r_t;
    logic [14:0]        r_t2;
    logic [29:0]        r_m;
    logic               r_neg;

    // rotation
    logic               r_rp;
    logic [CW-1:0]      r_ri;
    logic [1:0]         r_rph;
    logic signed [15:0] r_vx;
    logic signed [15:0] r_vy;
    logic signed [31:0] r_xc;
    logic signed [31:0] r_ys;
    logic signed [31:0] r_xs;
    logic signed [31:0] r_yc;

    // edges and projection
    logic               r_pe;
    logic [CW-1:0]      r_ei;
    logic signed [LW-1:0] r_lx;
    logic signed [LW-1:0] r_ly;
    logic signed [LW-1:0] r_ix;
    logic signed [LW-1:0] r_iy;
    logic signed [NW-1:0] r_nx;
    logic signed [NW-1:0] r_ny;
    logic               r_issue;
    logic               r_iq;
    logic [CW-1:0]      r_ik;
    logic               r_s1v, r_s1p, r_s1f;
    logic               r_s2v, r_s2p, r_s2f;
    logic               r_s3v, r_s3p, r_s3f;
    logic signed [GW-1:0] r_gx;
    logic signed [GW-1:0] r_gy;
    logic signed [PW-1:0] r_pxx;
    logic signed [PW-1:0] r_pyy;
    logic signed [DW-1:0] r_lo [2];
    logic signed [DW-1:0] r_hi [2];

    logic               r_out_valid;

    // combinational helpers
    logic               w_pop;
    logic               w_fire;
    logic [11:0]        w_a;
    logic [10:0]        w_qq;
    logic [14:0]        w_t;
    logic [15:0]        w_sv;
    logic signed [33:0] w_rx;
    logic signed [33:0] w_ry;
    logic [AW-1:0]      w_st_ra;
    logic               w_loc_we;
    logic [AW-1:0]      w_loc_a;
    logic [AW-1:0]      w_loc_ra;
    logic [CW-1:0]      w_rn;
    logic [CW-1:0]      w_en;
    logic [CW-1:0]      w_ej;
    logic [CW-1:0]      w_qn;
    logic signed [DW-1:0] w_d;
    logic               w_sep;

    assign w_pop  = (r_state == S_IDLE) && i_valid;
    assign o_pop  = w_pop;
    // a finished test moves into the output register once it is free
    assign w_fire = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign o_valid    = r_out_valid;
    assign o_collides = r_res_col;
    assign o_overflow = r_res_ovf;

    always_comb begin
        w_a  = r_ang[r_tk[1]] + (r_tk[0] ? cpsat_pkg::ANG_QTR : 12'd0);
        w_qq = w_a[10] ? (cpsat_pkg::QTR_Q - {1'b0, w_a[9:0]}) : {1'b0, w_a[9:0]};
        w_t  = {w_qq, 4'b0000};
        w_sv = r_neg ? (16'd0 - r_m[29:14]) : r_m[29:14];
        w_rx = 34'(r_xc) - 34'(r_ys) + cpsat_pkg::ROT_RND;
        w_ry = 34'(r_xs) + 34'(r_yc) + cpsat_pkg::ROT_RND;
        w_st_ra  = {r_rp, r_ri[IW-1:0]};
        w_loc_we = (r_state == S_ROT) && (r_rph == 2'd2);
        w_loc_a  = {r_rp, r_ri[IW-1:0]};
        w_rn = r_rp ? r_cnt_b : r_cnt_a;
        w_en = r_pe ? r_cnt_b : r_cnt_a;
        w_ej = ((r_ei + CW'(1)) < w_en) ? (r_ei + CW'(1)) : '0;
        w_qn = r_iq ? r_cnt_b : r_cnt_a;
        case (r_state)
            S_EDGE0: w_loc_ra = {r_pe, r_ei[IW-1:0]};
            S_EDGE1: w_loc_ra = {r_pe, w_ej[IW-1:0]};
            default: w_loc_ra = {r_iq, r_ik[IW-1:0]};
        endcase
        w_d   = DW'(r_pxx) + DW'(r_pyy);
        w_sep = !((r_lo[0] >= r_lo[1] && r_lo[0] <= r_hi[1]) ||
                  (r_lo[1] >= r_lo[0] && r_lo[1] <= r_hi[0]));
    end

    // vertex store
    always_ff @(posedge i_clk) begin
        if (w_pop && w_we) begin
            r_st_x[w_waddr] <= w_vtx.vtx_x;
            r_st_y[w_waddr] <= w_vtx.vtx_y;
        end
        r_vx <= r_st_x[w_st_ra];
        r_vy <= r_st_y[w_st_ra];
    end

    // rotated local vertices
    always_ff @(posedge i_clk) begin
        if (w_loc_we) begin
            r_loc_x[w_loc_a] <= w_rx[33:14];
            r_loc_y[w_loc_a] <= w_ry[33:14];
        end
        r_lx <= r_loc_x[w_loc_ra];
        r_ly <= r_loc_y[w_loc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pose_x[0] <= '0;
            r_pose_x[1] <= '0;
            r_pose_y[0] <= '0;
            r_pose_y[1] <= '0;
            r_ang[0]    <= '0;
            r_ang[1]    <= '0;
            r_issue     <= 1'b0;
            r_s1v       <= 1'b0;
            r_s2v       <= 1'b0;
            r_s3v       <= 1'b0;
        end else begin
            if (w_fire) r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready) r_out_valid <= 1'b0;

            // projection pipe: read, place, multiply, min/max
            r_s1v <= r_issue;
            r_s1p <= r_iq;
            r_s1f <= (r_ik == '0);
            r_s2v <= r_s1v;
            r_s2p <= r_s1p;
            r_s2f <= r_s1f;
            r_gx  <= GW'(r_pose_x[r_s1p]) + GW'(r_lx);
            r_gy  <= GW'(r_pose_y[r_s1p]) + GW'(r_ly);
            r_s3v <= r_s2v;
            r_s3p <= r_s2p;
            r_s3f <= r_s2f;
            r_pxx <= PW'(r_gx) * PW'(r_nx);
            r_pyy <= PW'(r_gy) * PW'(r_ny);
            if (r_s3v) begin
                if (r_s3f || w_d < r_lo[r_s3p]) r_lo[r_s3p] <= w_d;
                if (r_s3f || w_d > r_hi[r_s3p]) r_hi[r_s3p] <= w_d;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid && w_vtx.last) begin
                        r_pose_x[w_vtx.sel] <= w_vtx.pos_x;
                        r_pose_y[w_vtx.sel] <= w_vtx.pos_y;
                        r_ang[w_vtx.sel]    <= w_vtx.angle;
                        if (w_vtx.sel) begin
                            r_cnt_a   <= w_cnt_a;
                            r_cnt_b   <= w_cnt_b;
                            r_tst_ovf <= w_ovf;
                            r_tk      <= 2'd0;
                            r_ts      <= 3'd0;
                            if (w_cnt_a == '0 || w_cnt_b == '0) begin
                                r_tst_col <= 1'b0;
                                r_state   <= S_DONE;
                            end else begin
                                r_state <= S_TRIG;
                            end
                        end
                    end
                end
                S_TRIG: begin
                    case (r_ts)
                        3'd0: begin
                            r_ts  <= r_ts + 3'd1;
                            r_t   <= w_t;
                            r_neg <= w_a[11];
                            r_m   <= 30'(w_t) * 30'(w_t);
                        end
                        3'd1: begin
                            r_ts <= r_ts + 3'd1;
                            r_t2 <= r_m[28:14];
                            r_m  <= 30'(r_m[28:14]) * 30'(cpsat_pkg::SIN_K1);
                        end
                        3'd2: begin
                            r_ts <= r_ts + 3'd1;
                            r_m  <= 30'(r_t2) * 30'(cpsat_pkg::SIN_K0 - r_m[28:14]);
                        end
                        3'd3: begin
                            r_ts <= r_ts + 3'd1;
                            r_m  <= 30'(r_t) * 30'(cpsat_pkg::SIN_K2 - r_m[29:14]);
                        end
                        default: begin
                            if (r_tk[0]) r_cos[r_tk[1]] <= w_sv;
                            else         r_sin[r_tk[1]] <= w_sv;
                            r_ts <= 3'd0;
                            r_tk <= r_tk + 2'd1;
                            if (r_tk == 2'd3) begin
                                r_rp    <= 1'b0;
                                r_ri    <= '0;
                                r_rph   <= 2'd0;
                                r_state <= S_ROT;
                            end
                        end
                    endcase
                end
                S_ROT: begin
                    case (r_rph)
                        2'd0: r_rph <= 2'd1;
                        2'd1: begin
                            r_xc  <= 32'(r_vx) * 32'(r_cos[r_rp]);
                            r_ys  <= 32'(r_vy) * 32'(r_sin[r_rp]);
                            r_xs  <= 32'(r_vx) * 32'(r_sin[r_rp]);
                            r_yc  <= 32'(r_vy) * 32'(r_cos[r_rp]);
                            r_rph <= 2'd2;
                        end
                        default: begin
                            r_rph <= 2'd0;
                            if ((r_ri + CW'(1)) < w_rn) begin
                                r_ri <= r_ri + CW'(1);
                            end else if (!r_rp) begin
                                r_rp <= 1'b1;
                                r_ri <= '0;
                            end else begin
                                r_pe    <= 1'b0;
                                r_ei    <= '0;
                                r_state <= S_EDGE0;
                            end
                        end
                    endcase
                end
                S_EDGE0: r_state <= S_EDGE1;
                S_EDGE1: begin
                    r_ix    <= r_lx;
                    r_iy    <= r_ly;
                    r_state <= S_EDGE2;
                end
                S_EDGE2: begin
                    r_nx    <= NW'(r_iy) - NW'(r_ly);
                    r_ny    <= NW'(r_lx) - NW'(r_ix);
                    r_iq    <= 1'b0;
                    r_ik    <= '0;
                    r_issue <= 1'b1;
                    r_state <= S_PROJ;
                end
                S_PROJ: begin
                    if (r_issue) begin
                        if ((r_ik + CW'(1)) < w_qn) begin
                            r_ik <= r_ik + CW'(1);
                        end else if (!r_iq) begin
                            r_iq <= 1'b1;
                            r_ik <= '0;
                        end else begin
                            r_issue <= 1'b0;
                        end
                    end else if (!r_s1v && !r_s2v && !r_s3v) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_sep) begin
                        r_tst_col <= 1'b0;
                        r_state   <= S_DONE;
                    end else if ((r_ei + CW'(1)) < w_en) begin
                        r_ei    <= r_ei + CW'(1);
                        r_state <= S_EDGE0;
                    end else if (!r_pe) begin
                        r_pe    <= 1'b1;
                        r_ei    <= '0;
                        r_state <= S_EDGE0;
                    end else begin
                        r_tst_col <= 1'b1;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_fire) begin
                        r_res_col <= r_tst_col;
                        r_res_ovf <= r_tst_ovf;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/convex_polygon_sat_collision_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_polygon_sat_collision_core
// separating-axis collision test of two convex polygons loaded vertex by vertex
// ----------------------------------------------------------------------------
// usage:
//   the slave stream takes one vertex word per handshake; tuser selects
//   polygon a (0) or b (1), tlast marks that polygon's final vertex and carries
//   its position and angle. tlast on polygon b starts the test, and one word
//   {overflow, collides} leaves on the master stream for it.
// timing:
//   vertex words that start no test are taken by the idle engine and are
//   buffered by a two-entry queue, so loading runs at one word per cycle
//   while no test is running. a test rotates both polygons, then projects
//   them onto the normal of each edge of both; the projection pipe streams one
//   vertex a cycle through one dot product. a test stops at the first
//   separating axis. an empty polygon answers at once with collides = 0.
// reset:
//   synchronous, active low; clears counts, poses and the overflow flag.
// stalls:
//   the result waits in an output register while tready is low; loading of
//   the next pair continues until the queue fills.
// ----------------------------------------------------------------------------
module convex_polygon_sat_collision_core #(
    parameter int MAX_VERTICES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // vertex_x [15:0], vertex_y [31:16], pos_x [55:32], pos_y [79:56], angle [91:80]
    input  logic [95:0] i_s_axis_tdata,
    // polygon_sel
    input  logic        i_s_axis_tuser,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // collides [0], overflow [1]
    output logic [7:0]  o_m_axis_tdata
);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int IW = $clog2(MAX_VERTICES);
    localparam int QW = cpsat_pkg::VTX_W + 1 + (IW + 1) + 2 * CW + 1;

    cpsat_pkg::t_vtx w_vtx;
    logic            w_push;
    logic            w_full;
    logic [QW-1:0]   w_qin;
    logic            w_qvalid;
    logic            w_pop;
    logic [QW-1:0]   w_qout;
    logic            w_col;
    logic            w_ovf;

    always_comb begin
        w_vtx.vtx_x = i_s_axis_tdata[15:0];
        w_vtx.vtx_y = i_s_axis_tdata[31:16];
        w_vtx.pos_x = i_s_axis_tdata[55:32];
        w_vtx.pos_y = i_s_axis_tdata[79:56];
        w_vtx.angle = i_s_axis_tdata[91:80];
        w_vtx.sel   = i_s_axis_tuser;
        w_vtx.last  = i_s_axis_tlast;
    end

    cpsat_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_vtx   (w_vtx),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_entry (w_qin)
    );

    cpsat_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_qin),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_data  (w_qout)
    );

    cpsat_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_qvalid),
        .o_pop      (w_pop),
        .i_entry    (w_qout),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_collides (w_col),
        .o_overflow (w_ovf)
    );

    assign o_m_axis_tdata = {6'b000000, w_ovf, w_col};

endmodule

// ----- tb/sv/convex_polygon_sat_collision_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_polygon_sat_collision_core_tb
// self-checking bench: directed table then random polygon pairs, compared
// against a fixed-point separating-axis predictor, under several sender idle and receiver stall phases
// ----------------------------------------------------------------------------
module convex_polygon_sat_collision_core_tb;

    localparam int MAXV = 16;
    localparam int NO_CHECK = 2;

    typedef struct {
        logic               sel;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic        [11:0] ang;
        logic               last;
        int                 want;   // typed-in collides value, or NO_CHECK
    } vtx_row_t;

    typedef struct {
        logic collides;
        logic overflow;
    } verdict_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;

    convex_polygon_sat_collision_core #(.MAX_VERTICES(MAXV)) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic signed [15:0] sx[2][MAXV];
    logic signed [15:0] sy[2][MAXV];
    int                 cnt[2];
    logic signed [23:0] pose_px[2];
    logic signed [23:0] pose_py[2];
    logic        [11:0] pose_ang[2];
    logic               dropped;

    verdict_t verdict_q[$];
    int       want_q[$];
    int       sender_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       n_errors = 0;
    int       n_results = 0;

    function automatic longint quarter_sine(int unsigned q);
        int unsigned t, t2, inner, mid;
        t = q << 4;
        t2 = (t * t) >> 14;
        inner = 10512 - ((t2 * 1160) >> 14);
        mid = 25736 - ((t2 * inner) >> 14);
        return longint'((t * mid) >> 14);
    endfunction

    function automatic longint sine_q14(int unsigned a);
        int unsigned q;
        q = a & 1023;
        case ((a >> 10) & 3)
            0: return quarter_sine(q);
            1: return quarter_sine(1024 - q);
            2: return -quarter_sine(q);
            default: return -quarter_sine(1024 - q);
        endcase
    endfunction

    function automatic logic sat_overlap();
        longint gx[2][MAXV];
        longint gy[2][MAXV];
        longint lx[2][MAXV];
        longint ly[2][MAXV];
        longint s, c, nx, ny, d, lo[2], hi[2];
        int j;
        for (int p = 0; p < 2; p++) begin
            if (cnt[p] == 0) return 1'b0;
            s = sine_q14(pose_ang[p]);
            c = sine_q14((pose_ang[p] + 1024) & 4095);
            for (int i = 0; i < cnt[p]; i++) begin
                lx[p][i] = (longint'(sx[p][i]) * c - longint'(sy[p][i]) * s + 8192) >>> 14;
                ly[p][i] = (longint'(sx[p][i]) * s + longint'(sy[p][i]) * c + 8192) >>> 14;
                gx[p][i] = longint'(pose_px[p]) + lx[p][i];
                gy[p][i] = longint'(pose_py[p]) + ly[p][i];
            end
        end
        for (int p = 0; p < 2; p++) begin
            for (int i = 0; i < cnt[p]; i++) begin
                j = (i + 1 < cnt[p]) ? i + 1 : 0;
                nx = ly[p][i] - ly[p][j];
                ny = lx[p][j] - lx[p][i];
                for (int k = 0; k < 2; k++) begin
                    for (int v = 0; v < cnt[k]; v++) begin
                        d = gx[k][v] * nx + gy[k][v] * ny;
                        if (v == 0 || d < lo[k]) lo[k] = d;
                        if (v == 0 || d > hi[k]) hi[k] = d;
                    end
                end
                if (!((lo[0] >= lo[1] && lo[0] <= hi[1]) ||
                      (lo[1] >= lo[0] && lo[1] <= hi[0])))
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_vertex(vtx_row_t r);
        int p;
        verdict_t v;
        p = r.sel;
        if (cnt[p] < MAXV) begin
            sx[p][cnt[p]] = r.vx;
            sy[p][cnt[p]] = r.vy;
            cnt[p]++;
        end else begin
            dropped = 1'b1;
        end
        if (!r.last) return;
        pose_px[p] = r.px;
        pose_py[p] = r.py;
        pose_ang[p] = r.ang;
        if (p == 0) return;
        v.collides = sat_overlap();
        v.overflow = dropped;
        verdict_q.push_back(v);
        want_q.push_back(r.want);
        cnt[0] = 0;
        cnt[1] = 0;
        dropped = 1'b0;
    endfunction

    // tvalid stays high between words unless the sender idles
    task automatic send_vertex(vtx_row_t r);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {4'd0, r.ang, r.py, r.px, r.vy, r.vx};
        i_s_axis_tuser <= r.sel;
        i_s_axis_tlast <= r.last;
        predict_vertex(r);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // receiver side: random stall, compare each word
    always @(posedge i_clk) begin
        verdict_t v;
        int w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_results++;
            if (verdict_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected word %h", o_m_axis_tdata);
            end else begin
                v = verdict_q.pop_front();
                w = want_q.pop_front();
                if (o_m_axis_tdata[0] !== v.collides || o_m_axis_tdata[1] !== v.overflow ||
                    o_m_axis_tdata[7:2] !== 6'd0 ||
                    (w != NO_CHECK && o_m_axis_tdata[0] !== w[0])) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch word %0d: exp collides %b overflow %b, got %h",
                                 n_results, v.collides, v.overflow, o_m_axis_tdata);
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic vtx_row_t mk(logic sel, int vx, int vy, int px, int py, int ang,
                                    logic last, int want);
        vtx_row_t r;
        r.sel = sel; r.vx = 16'(vx); r.vy = 16'(vy); r.px = 24'(px); r.py = 24'(py);
        r.ang = 12'(ang); r.last = last; r.want = want;
        return r;
    endfunction

    // regular convex polygon of the given radius around the given center, at a random base angle
    task automatic send_polygon(logic sel, int n, int spread, int cx, int cy);
        int base_ang, r, step, a;
        vtx_row_t row;
        base_ang = $urandom_range(4095);
        step = 4096 / n;
        for (int i = 0; i < n; i++) begin
            r = spread;
            a = (base_ang + i * step) & 4095;
            row = mk(sel, int'(sine_q14((a + 1024) & 4095) * r / 16384),
                     int'(sine_q14(a) * r / 16384),
                     cx, cy, $urandom_range(4095), i == n - 1, NO_CHECK);
            send_vertex(row);
        end
    endtask

    task automatic send_noise_vertex();
        vtx_row_t r;
        r = mk($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom_range(3) == 0, NO_CHECK);
        send_vertex(r);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    vtx_row_t dir_rows[$];

    initial begin
        int cx, cy, span;
        cnt[0] = 0; cnt[1] = 0; dropped = 1'b0;
        for (int p = 0; p < 2; p++) begin
            pose_px[p] = '0; pose_py[p] = '0; pose_ang[p] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty polygon a after reset: no collision
        dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 1, 0));
        // single vertex each at same spot: zero normals, overlaps
        dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, NO_CHECK));
        dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 1, 1));
        // extreme coordinates and poses, full angle range
        dir_rows.push_back(mk(0, -32768, -32768, -8388608, 8388607, 4095, 0, NO_CHECK));
        dir_rows.push_back(mk(0, 32767, -32768, 0, 0, 0, 0, NO_CHECK));
        dir_rows.push_back(mk(0, 32767, 32767, -8388608, -8388608, 2048, 1, NO_CHECK));
        dir_rows.push_back(mk(1, -32768, 32767, 8388607, 8388607, 1024, 0, NO_CHECK));
        dir_rows.push_back(mk(1, 32767, 32767, 8388607, -8388608, 3072, 0, NO_CHECK));
        dir_rows.push_back(mk(1, 0, -32768, 8388607, 8388607, 4095, 1, 0));
        // overlapping triangles
        dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, NO_CHECK));
        dir_rows.push_back(mk(0, 2560, 0, 0, 0, 0, 0, NO_CHECK));
        dir_rows.push_back(mk(0, 0, 2560, 0, 0, 0, 1, NO_CHECK));
        dir_rows.push_back(mk(1, 0, 0, 256, 256, 0, 0, NO_CHECK));
        dir_rows.push_back(mk(1, 2560, 0, 256, 256, 0, 0, NO_CHECK));
        dir_rows.push_back(mk(1, 0, 2560, 256, 256, 1, 1, 1));
        // last of a with b empty, then b alone: a counts reset to 0 after a test
        dir_rows.push_back(mk(0, 100, 100, 5, 5, 512, 1, NO_CHECK));
        dir_rows.push_back(mk(1, -5, 7, 0, 0, 0, 1, NO_CHECK));
        foreach (dir_rows[i]) send_vertex(dir_rows[i]);

        // store overflow: 18 vertices on a, touching squares test for b
        for (int i = 0; i < 18; i++)
            send_vertex(mk(0, (i & 1) ? 512 : 0, (i & 2) ? 512 : 0, 0, 0, 0, i == 17,
                           NO_CHECK));
        for (int i = 0; i < 4; i++)
            send_vertex(mk(1, (i == 1 || i == 2) ? 512 : 0, (i >= 2) ? 512 : 0,
                           512, 0, 0, i == 3, NO_CHECK));

        // pause until every result is back
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            for (int pair = 0; pair < 12; pair++) begin
                cx = $urandom_range(4000) - 2000;
                cy = $urandom_range(4000) - 2000;
                span = $urandom_range(3000) + 200;
                if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(4) + 1) send_noise_vertex();
                end
                send_polygon(0, $urandom_range(7) + 1, span, cx, cy);
                send_polygon(1, ($urandom_range(19) == 0) ? MAXV + 2 : $urandom_range(7) + 1,
                             $urandom_range(3000) + 200,
                             cx + $urandom_range(2 * span) - span,
                             cy + $urandom_range(2 * span) - span);
            end
        end
        wait_drained();
        repeat (2000) @(posedge i_clk);
        if (n_errors == 0 && verdict_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
